### sv/htd_pkg.sv
// Shared types and constants of the Huffman tree decoder.
`timescale 1ns / 1ps

package htd_pkg;

	// Defaults for the top-level parameters
	localparam int NODE_COUNT_DEF   = 512;
	localparam int MAX_CODE_LEN_DEF = 64;

	// Fixed field widths
	localparam int BYTE_BITS  = 8;
	localparam int COUNT_W    = 32;
	localparam int CODE_W     = 64;
	localparam int CMD_W      = 2;
	localparam int IN_DATA_W  = 120;
	localparam int OUT_DATA_W = 16;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_START = 2'd0;
	localparam logic [CMD_W-1:0] CMD_ENTRY = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

	// Result kinds
	localparam logic KIND_SYMBOL = 1'b0;
	localparam logic KIND_ERROR  = 1'b1;

	// Error codes
	localparam logic [1:0] ERR_NONE   = 2'd0;
	localparam logic [1:0] ERR_LENGTH = 2'd1;
	localparam logic [1:0] ERR_FULL   = 2'd2;
	localparam logic [1:0] ERR_BRANCH = 2'd3;

	// One result, without its last-of-request flag
	typedef struct packed {
		logic                 kind;
		logic [BYTE_BITS-1:0] symbol;
		logic [1:0]           error_code;
		logic                 block_end;
	} res_t;

	// Core to result stage
	typedef struct packed {
		logic push;
		logic close;
		res_t res;
	} res_ctl_t;

	// Result stage to core
	typedef struct packed {
		logic push_ok;
		logic close_ok;
	} res_sts_t;

endpackage

### sv/htd_node_ram.sv
// Node store of the code tree: one write port, one registered read port.
`timescale 1ns / 1ps

module htd_node_ram #(
	parameter int DEPTH = 512,
	parameter int AW    = 9,
	parameter int DW    = 26
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rd_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[raddr];
		end
	end

	assign rdata = rd_q;

endmodule

### sv/htd_result_stage.sv
// Result staging: one held result and the output register of the result stream.
`timescale 1ns / 1ps

module htd_result_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  htd_pkg::res_ctl_t                   ctl,
	output htd_pkg::res_sts_t                   sts,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// symbol[7:0], error_code[9:8], block_end[10], zero fill
	output logic [htd_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
	// kind[0]
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast
);

	import htd_pkg::*;

	logic pend_v_q;
	res_t pend_q;
	logic out_v_q;
	res_t out_q;
	logic out_last_q;
	logic move_ok;
	logic do_push;
	logic do_close;

	// The held result may move on when the output register frees up
	assign move_ok      = !out_v_q || m_axis_tready;
	assign sts.push_ok  = !pend_v_q || move_ok;
	assign sts.close_ok = !pend_v_q || move_ok;
	assign do_push      = ctl.push && sts.push_ok;
	assign do_close     = ctl.close && !ctl.push && sts.close_ok;

	// Valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if ((do_push || do_close) && pend_v_q) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && m_axis_tready) begin
				out_v_q <= 1'b0;
			end
			if (do_push) begin
				pend_v_q <= 1'b1;
			end else if (do_close) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Payload: a new result proves the held one is not the last of its request
	always_ff @(posedge clk) begin
		if (do_push) begin
			if (pend_v_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
			pend_q <= ctl.res;
		end else if (do_close && pend_v_q) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {5'd0, out_q.block_end, out_q.error_code, out_q.symbol};
	assign m_axis_tuser  = out_q.kind;
	assign m_axis_tlast  = out_last_q;

endmodule

### sv/htd_core.sv
// Sequencer: inserts codes one bit per step and walks data bytes bit by bit.
`timescale 1ns / 1ps

module htd_core #(
	parameter int NODE_COUNT   = 512,
	parameter int MAX_CODE_LEN = 64,
	parameter int AW           = 9,
	parameter int WW           = 26
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [htd_pkg::CMD_W-1:0]         cmd,
	input  logic [htd_pkg::COUNT_W-1:0]       block_symbols,
	input  logic [htd_pkg::BYTE_BITS-1:0]     entry_symbol,
	input  logic [htd_pkg::BYTE_BITS-1:0]     code_length,
	input  logic [htd_pkg::CODE_W-1:0]        code_value,
	input  logic [htd_pkg::BYTE_BITS-1:0]     packed_byte,
	output logic                              ram_we,
	output logic [AW-1:0]                     ram_waddr,
	output logic [WW-1:0]                     ram_wdata,
	output logic                              ram_re,
	output logic [AW-1:0]                     ram_raddr,
	input  logic [WW-1:0]                     ram_rdata,
	output htd_pkg::res_ctl_t                 res_ctl,
	input  htd_pkg::res_sts_t                 res_sts
);

	import htd_pkg::*;

	localparam int NW = AW + 1;
	localparam int IW = (MAX_CODE_LEN > 1) ? $clog2(MAX_CODE_LEN) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS,
		ST_INS_RD,
		ST_INS_FIN,
		ST_WALK,
		ST_CLOSE
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           root_left_q;
	logic [AW-1:0]           root_right_q;
	logic [NW-1:0]           nodes_q;
	logic [AW-1:0]           pos_q;
	logic [COUNT_W-1:0]      target_q;
	logic [COUNT_W-1:0]      decoded_q;
	logic                    halted_q;
	logic                    bad_q;
	logic                    fin_q;
	logic                    rd_pend_q;
	logic [AW-1:0]           cur_q;
	logic [AW-1:0]           nxt_q;
	logic [AW-1:0]           cw_left_q;
	logic [AW-1:0]           cw_right_q;
	logic [BYTE_BITS-1:0]    cw_leaf_q;
	logic [MAX_CODE_LEN-1:0] code_q;
	logic [BYTE_BITS-1:0]    sym_q;
	logic [IW-1:0]           idx_q;
	logic [BYTE_BITS-1:0]    byte_q;
	logic [3:0]              bits_q;

	logic [AW-1:0]           rd_left;
	logic [AW-1:0]           rd_right;
	logic [BYTE_BITS-1:0]    rd_leaf;
	logic                    rd_is_leaf;
	logic                    sym_hit;
	logic [AW-1:0]           w_left;
	logic [AW-1:0]           w_right;
	logic [AW-1:0]           w_next;
	logic                    w_miss;
	logic [COUNT_W-1:0]      dec_inc;
	logic                    hit_done;
	logic                    count_reached;
	logic                    ins_bit;
	logic [AW-1:0]           slot;
	logic                    slot_free;
	logic                    store_full;
	logic [AW-1:0]           new_node;
	logic                    len_bad;

	// Fields of the node word just read: {left, right, leaf}
	assign rd_left  = ram_rdata[WW-1 -: AW];
	assign rd_right = ram_rdata[BYTE_BITS +: AW];
	assign rd_leaf  = ram_rdata[BYTE_BITS-1:0];

	// Walk step: resolve the node last read, then follow the next bit
	assign rd_is_leaf = (rd_left == '0) && (rd_right == '0);
	assign sym_hit    = rd_pend_q && rd_is_leaf;
	assign w_left     = rd_pend_q ? rd_left : cw_left_q;
	assign w_right    = rd_pend_q ? rd_right : cw_right_q;
	assign w_next     = byte_q[BYTE_BITS-1] ? w_right : w_left;
	assign w_miss     = (w_next == '0);

	// Block count
	assign dec_inc       = decoded_q + COUNT_W'(1);
	assign hit_done      = (target_q != '0) && (dec_inc == target_q);
	assign count_reached = (target_q != '0) && (decoded_q == target_q);

	// Insert step
	assign ins_bit    = code_q[idx_q];
	assign slot       = ins_bit ? cw_right_q : cw_left_q;
	assign slot_free  = (slot == '0);
	assign store_full = (nodes_q == NW'(NODE_COUNT));
	assign new_node   = nodes_q[AW-1:0];
	assign len_bad    = (code_length == '0) || (code_length > BYTE_BITS'(MAX_CODE_LEN));

	assign in_ready = (state_q == ST_IDLE);

	// Memory ports and result requests
	always_comb begin
		ram_we                     = 1'b0;
		ram_waddr                  = cur_q;
		ram_wdata                  = {cw_left_q, cw_right_q, cw_leaf_q};
		ram_re                     = 1'b0;
		ram_raddr                  = w_next;
		res_ctl                    = '0;
		res_ctl.res.kind           = KIND_ERROR;
		res_ctl.res.error_code     = ERR_NONE;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && cmd == CMD_DATA && !halted_q && !count_reached
						&& pos_q != '0) begin
					ram_re    = 1'b1;
					ram_raddr = pos_q;
				end
			end
			ST_INS: begin
				if (bad_q) begin
					res_ctl.push           = 1'b1;
					res_ctl.res.error_code = ERR_LENGTH;
				end else if (slot_free && store_full) begin
					// keep a freshly allocated node consistent
					res_ctl.push           = 1'b1;
					res_ctl.res.error_code = ERR_FULL;
					ram_we                 = res_sts.push_ok && (cur_q != '0);
				end else if (slot_free) begin
					ram_we    = (cur_q != '0);
					ram_wdata = {ins_bit ? cw_left_q : new_node,
						ins_bit ? new_node : cw_right_q, cw_leaf_q};
				end else begin
					ram_re    = 1'b1;
					ram_raddr = slot;
				end
			end
			ST_INS_RD: begin
			end
			ST_INS_FIN: begin
				ram_we    = 1'b1;
				ram_wdata = {cw_left_q, cw_right_q, sym_q};
			end
			ST_WALK: begin
				if (sym_hit) begin
					res_ctl.push          = 1'b1;
					res_ctl.res.kind      = KIND_SYMBOL;
					res_ctl.res.symbol    = rd_leaf;
					res_ctl.res.block_end = hit_done;
				end else if (bits_q != '0) begin
					if (w_miss) begin
						res_ctl.push           = 1'b1;
						res_ctl.res.error_code = ERR_BRANCH;
					end else begin
						ram_re = 1'b1;
					end
				end
			end
			ST_CLOSE: begin
				res_ctl.close = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Sequencer state and tree bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			root_left_q  <= '0;
			root_right_q <= '0;
			nodes_q      <= NW'(1);
			pos_q        <= '0;
			target_q     <= '0;
			decoded_q    <= '0;
			halted_q     <= 1'b0;
			bad_q        <= 1'b0;
			fin_q        <= 1'b0;
			rd_pend_q    <= 1'b0;
			cur_q        <= '0;
			nxt_q        <= '0;
			cw_left_q    <= '0;
			cw_right_q   <= '0;
			cw_leaf_q    <= '0;
			code_q       <= '0;
			sym_q        <= '0;
			idx_q        <= '0;
			byte_q       <= '0;
			bits_q       <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						unique case (cmd)
							CMD_START: begin
								root_left_q  <= '0;
								root_right_q <= '0;
								nodes_q      <= NW'(1);
								pos_q        <= '0;
								target_q     <= block_symbols;
								decoded_q    <= '0;
								halted_q     <= 1'b0;
							end
							CMD_ENTRY: begin
								if (!halted_q) begin
									bad_q      <= len_bad;
									idx_q      <= IW'(code_length - BYTE_BITS'(1));
									code_q     <= code_value[MAX_CODE_LEN-1:0];
									sym_q      <= entry_symbol;
									cur_q      <= '0;
									cw_left_q  <= root_left_q;
									cw_right_q <= root_right_q;
									cw_leaf_q  <= '0;
									state_q    <= ST_INS;
								end
							end
							CMD_DATA: begin
								if (!halted_q && !count_reached) begin
									byte_q     <= packed_byte;
									bits_q     <= 4'(BYTE_BITS);
									cw_left_q  <= root_left_q;
									cw_right_q <= root_right_q;
									nxt_q      <= pos_q;
									rd_pend_q  <= (pos_q != '0);
									state_q    <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_INS: begin
					if (bad_q || (slot_free && store_full)) begin
						if (res_sts.push_ok) begin
							halted_q <= 1'b1;
							pos_q    <= '0;
							state_q  <= ST_CLOSE;
						end
					end else if (slot_free) begin
						// grow a node off the current one
						if (cur_q == '0) begin
							if (ins_bit) begin
								root_right_q <= new_node;
							end else begin
								root_left_q <= new_node;
							end
						end
						nodes_q    <= nodes_q + NW'(1);
						cur_q      <= new_node;
						cw_left_q  <= '0;
						cw_right_q <= '0;
						cw_leaf_q  <= '0;
						if (idx_q == '0) begin
							state_q <= ST_INS_FIN;
						end else begin
							idx_q <= idx_q - IW'(1);
						end
					end else begin
						cur_q <= slot;
						fin_q <= (idx_q == '0);
						if (idx_q != '0) begin
							idx_q <= idx_q - IW'(1);
						end
						state_q <= ST_INS_RD;
					end
				end
				ST_INS_RD: begin
					cw_left_q  <= rd_left;
					cw_right_q <= rd_right;
					cw_leaf_q  <= rd_leaf;
					state_q    <= fin_q ? ST_INS_FIN : ST_INS;
				end
				ST_INS_FIN: begin
					state_q <= ST_IDLE;
				end
				ST_WALK: begin
					if (sym_hit) begin
						// leaf reached: back to the root
						if (res_sts.push_ok) begin
							decoded_q  <= dec_inc;
							pos_q      <= '0;
							cw_left_q  <= root_left_q;
							cw_right_q <= root_right_q;
							rd_pend_q  <= 1'b0;
							if (hit_done || bits_q == '0) begin
								state_q <= ST_CLOSE;
							end
						end
					end else if (bits_q == '0) begin
						if (rd_pend_q) begin
							pos_q <= nxt_q;
						end
						rd_pend_q <= 1'b0;
						state_q   <= ST_CLOSE;
					end else if (w_miss) begin
						if (res_sts.push_ok) begin
							halted_q  <= 1'b1;
							pos_q     <= '0;
							rd_pend_q <= 1'b0;
							state_q   <= ST_CLOSE;
						end
					end else begin
						nxt_q     <= w_next;
						rd_pend_q <= 1'b1;
						byte_q    <= {byte_q[BYTE_BITS-2:0], 1'b0};
						bits_q    <= bits_q - 4'd1;
					end
				end
				ST_CLOSE: begin
					if (res_sts.close_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### sv/huffman_tree_decoder.sv
// Top level of the Huffman tree decoder.
`timescale 1ns / 1ps

// Decodes Huffman-coded blocks against a code tree loaded per block. Requests arrive on
// the s_axis stream with the command in tuser: a start request clears the tree and sets
// the block's symbol count (0 = unlimited); an entry request inserts a code MSB first,
// allocating a node where a branch is missing and reading an existing node otherwise; a
// data byte is walked MSB first, one tree level per cycle while the result stage accepts
// results, through the single read port of the node store (the saved walk position is
// fetched in the accepting cycle). The walk also resolves each decoded symbol, settles a
// walk that stops between leaves, closes the request and returns to idle; an error or
// the block's last symbol ends a byte early. Results (decoded symbols or error reports,
// kind in tuser) leave on m_axis, tlast on the last result of each request. After an
// error the block ignores entries and data until the next start. A new request is taken
// while the previous request's final result still waits in the output register.
module huffman_tree_decoder #(
	parameter int NODE_COUNT   = htd_pkg::NODE_COUNT_DEF,
	parameter int MAX_CODE_LEN = htd_pkg::MAX_CODE_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// block_symbols[31:0], entry_symbol[39:32], code_length[47:40],
	// code_value[111:48], packed_byte[119:112]
	input  logic [htd_pkg::IN_DATA_W-1:0]     s_axis_tdata,
	// cmd[1:0]
	input  logic [htd_pkg::CMD_W-1:0]         s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// symbol[7:0], error_code[9:8], block_end[10], zero fill
	output logic [htd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
	// kind[0]
	output logic                              m_axis_tuser,
	output logic                              m_axis_tlast
);

	import htd_pkg::*;

	localparam int AW = $clog2(NODE_COUNT);
	localparam int WW = 2 * AW + BYTE_BITS;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [WW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [WW-1:0] ram_rdata;
	res_ctl_t      res_ctl;
	res_sts_t      res_sts;

	// Request sequencer
	htd_core #(
		.NODE_COUNT  (NODE_COUNT),
		.MAX_CODE_LEN(MAX_CODE_LEN),
		.AW          (AW),
		.WW          (WW)
	) u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_axis_tvalid),
		.in_ready     (s_axis_tready),
		.cmd          (s_axis_tuser),
		.block_symbols(s_axis_tdata[31:0]),
		.entry_symbol (s_axis_tdata[39:32]),
		.code_length  (s_axis_tdata[47:40]),
		.code_value   (s_axis_tdata[111:48]),
		.packed_byte  (s_axis_tdata[119:112]),
		.ram_we       (ram_we),
		.ram_waddr    (ram_waddr),
		.ram_wdata    (ram_wdata),
		.ram_re       (ram_re),
		.ram_raddr    (ram_raddr),
		.ram_rdata    (ram_rdata),
		.res_ctl      (res_ctl),
		.res_sts      (res_sts)
	);

	// Node store
	htd_node_ram #(
		.DEPTH(NODE_COUNT),
		.AW   (AW),
		.DW   (WW)
	) u_node_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result staging and output register
	htd_result_stage u_result_stage (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (res_ctl),
		.sts          (res_sts),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

### tb/sv/huffman_tree_decoder_tb.sv
// Self-checking testbench of the Huffman tree decoder: directed table, then random blocks.
`timescale 1ns / 1ps

module huffman_tree_decoder_tb;
	import htd_pkg::*;

	localparam int NODES     = NODE_COUNT_DEF;
	localparam int MAX_LEN   = MAX_CODE_LEN_DEF;
	localparam int NODE_W    = $clog2(NODES);
	localparam int ITEM_GOAL = 420;

	// Command code the block ignores
	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

	// One request as the block takes it
	typedef struct packed {
		logic [CMD_W-1:0]     cmd;
		logic [COUNT_W-1:0]   block_symbols;
		logic [BYTE_BITS-1:0] entry_symbol;
		logic [BYTE_BITS-1:0] code_length;
		logic [CODE_W-1:0]    code_value;
		logic [BYTE_BITS-1:0] packed_byte;
	} request_t;

	// One result with its last-of-request flag
	typedef struct packed {
		logic                 kind;
		logic [BYTE_BITS-1:0] symbol;
		logic [1:0]           error_code;
		logic                 block_end;
		logic                 run_last;
	} outcome_t;

	// Directed row: a request and, where obvious, its single result or none
	typedef struct packed {
		request_t req;
		logic     known;
		logic     known_n;
		outcome_t known_res;
	} directed_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
	logic [CMD_W-1:0]      s_axis_tuser = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tuser;
	logic                  m_axis_tlast;

	// Predicted decoder state
	logic [NODE_W-1:0]    tree_left  [NODES];
	logic [NODE_W-1:0]    tree_right [NODES];
	logic [BYTE_BITS-1:0] tree_leaf  [NODES];
	logic [NODE_W:0]      node_total;
	logic [NODE_W-1:0]    walk_at;
	logic [COUNT_W-1:0]   block_target;
	logic [COUNT_W-1:0]   block_decoded;
	logic                 decode_halted;

	outcome_t results_due[$];
	int       fail_count = 0;
	int       items_done = 0;
	bit       idle_on = 1'b1;
	bit       hold_ask = 1'b0;

	huffman_tree_decoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #1 clk = ~clk;

	// Watchdog
	initial begin
		#1200000;
		$display("[huffman_tree_decoder] ERROR");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got_v,
		input logic [31:0] want_v);
		$display("%0t ns: %s got %0h, expected %0h", $time, what, got_v, want_v);
		fail_count++;
	endtask

	function automatic request_t make_request(input logic [CMD_W-1:0] cmd,
		input logic [31:0] count, input logic [7:0] sym, input logic [7:0] len,
		input logic [63:0] code, input logic [7:0] data_v);
		request_t r;
		r.cmd           = cmd;
		r.block_symbols = count;
		r.entry_symbol  = sym;
		r.code_length   = len;
		r.code_value    = code;
		r.packed_byte   = data_v;
		return r;
	endfunction

	// All fields random; callers override what matters
	function automatic request_t random_request();
		return make_request(CMD_W'($urandom_range(0, 3)), $urandom,
			8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), {$urandom, $urandom},
			8'($urandom_range(0, 255)));
	endfunction

	function automatic outcome_t error_outcome(input logic [1:0] code);
		outcome_t o;
		o.kind       = KIND_ERROR;
		o.symbol     = '0;
		o.error_code = code;
		o.block_end  = 1'b0;
		o.run_last   = 1'b1;
		return o;
	endfunction

	// Walk a code into the tree, allocating nodes; returns the error code
	function automatic logic [1:0] grow_code_path(input logic [7:0] sym,
		input logic [7:0] len, input logic [63:0] code);
		logic [NODE_W-1:0] cur;
		logic [NODE_W-1:0] slot;
		logic              b;
		if (len == 0 || len > MAX_LEN)
			return ERR_LENGTH;
		cur = '0;
		for (int i = 0; i < len; i++) begin
			b = code[len - 1 - i];
			slot = b ? tree_right[cur] : tree_left[cur];
			if (slot == '0) begin
				if (node_total >= (NODE_W + 1)'(NODES))
					return ERR_FULL;
				slot = node_total[NODE_W-1:0];
				tree_left[slot]  = '0;
				tree_right[slot] = '0;
				tree_leaf[slot]  = '0;
				node_total = node_total + 1'b1;
				if (b)
					tree_right[cur] = slot;
				else
					tree_left[cur] = slot;
			end
			cur = slot;
		end
		tree_leaf[cur] = sym;
		return ERR_NONE;
	endfunction

	// Update predicted state for one accepted request; queue its results if asked
	task automatic decode_request(input request_t r, input bit publish);
		outcome_t          found[$];
		outcome_t          o;
		logic [1:0]        err;
		logic [NODE_W-1:0] nxt;
		bit                done;
		case (r.cmd)
			CMD_START: begin
				tree_left[0]  = '0;
				tree_right[0] = '0;
				tree_leaf[0]  = '0;
				node_total    = (NODE_W + 1)'(1);
				walk_at       = '0;
				block_target  = r.block_symbols;
				block_decoded = '0;
				decode_halted = 1'b0;
			end
			CMD_ENTRY: begin
				if (!decode_halted) begin
					err = grow_code_path(r.entry_symbol, r.code_length, r.code_value);
					if (err != ERR_NONE) begin
						found.push_back(error_outcome(err));
						decode_halted = 1'b1;
						walk_at = '0;
					end
				end
			end
			CMD_DATA: begin
				if (!decode_halted && !(block_target != 0 && block_decoded == block_target)) begin
					for (int i = BYTE_BITS - 1; i >= 0; i--) begin
						nxt = r.packed_byte[i] ? tree_right[walk_at] : tree_left[walk_at];
						if (nxt == '0) begin
							found.push_back(error_outcome(ERR_BRANCH));
							decode_halted = 1'b1;
							walk_at = '0;
							break;
						end
						if (tree_left[nxt] == 0 && tree_right[nxt] == 0) begin
							block_decoded = block_decoded + 32'd1;
							done = block_target != 0 && block_decoded == block_target;
							o.kind       = KIND_SYMBOL;
							o.symbol     = tree_leaf[nxt];
							o.error_code = ERR_NONE;
							o.block_end  = done;
							o.run_last   = 1'b0;
							found.push_back(o);
							walk_at = '0;
							if (done || found.size() >= BYTE_BITS)
								break;
						end else begin
							walk_at = nxt;
						end
					end
				end
			end
			default: ;
		endcase
		if (publish) begin
			foreach (found[i]) begin
				o = found[i];
				o.run_last = (i == found.size() - 1);
				results_due.push_back(o);
			end
		end
	endtask

	// Offer one request, wait for acceptance, then predict
	task automatic offer(input request_t r, input bit publish);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r.packed_byte, r.code_value, r.code_length, r.entry_symbol,
			r.block_symbols};
		s_axis_tuser  <= r.cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_request(r, publish);
		items_done++;
	endtask

	// Sender stops and waits until every predicted result has come
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due.size() != 0)
			@(posedge clk);
	endtask

	// Result sink: random stalls, plus one long hold on request
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (hold_ask) begin
				hold_ask = 1'b0;
				stall_left = 300;
			end else if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 9);
			end
			if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Compare each accepted result with the oldest prediction
	always @(posedge clk) begin : result_check
		outcome_t got;
		outcome_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[9:8], m_axis_tdata[10],
				m_axis_tlast};
			if (results_due.size() == 0) begin
				report_mismatch("result with none pending", got, 0);
			end else begin
				want = results_due.pop_front();
				if (got.kind !== want.kind)
					report_mismatch("kind", got.kind, want.kind);
				if (got.symbol !== want.symbol)
					report_mismatch("symbol", got.symbol, want.symbol);
				if (got.error_code !== want.error_code)
					report_mismatch("error_code", got.error_code, want.error_code);
				if (got.block_end !== want.block_end)
					report_mismatch("block_end", got.block_end, want.block_end);
				if (got.run_last !== want.run_last)
					report_mismatch("tlast", got.run_last, want.run_last);
			end
		end
	end

	initial begin : stimulus
		directed_row_t plan[$];
		directed_row_t row;
		outcome_t      none;
		request_t      r;
		logic [7:0]    code_lens[$];
		logic [63:0]   code_vals[$];
		logic [63:0]   cv;
		int            phase_no;
		int            pick;
		int            leaves;
		int            max_len;
		int            idx;
		int            n_bytes;
		bit            hold_done;
		bit            hold_now;

		none = '0;
		hold_done = 1'b0;

		// Predicted state after reset: a lone root, no block, not halted
		tree_left[0]  = '0;
		tree_right[0] = '0;
		tree_leaf[0]  = '0;
		node_total    = (NODE_W + 1)'(1);
		walk_at       = '0;
		block_target  = '0;
		block_decoded = '0;
		decode_halted = 1'b0;

		// Directed table: request, known flag, known result count, known result
		row = {make_request(CMD_UNKNOWN, '1, 8'hFF, 8'hFF, '1, 8'hFF), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_START, 3, 0, 0, 0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		// zero length, then halted entry and data
		row = {make_request(CMD_ENTRY, 0, 8'h12, 0, 0, 0), 1'b1, 1'b1, error_outcome(ERR_LENGTH)};
		plan.push_back(row);
		row = {make_request(CMD_ENTRY, 0, 8'h12, 1, 0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'hFF), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_START, 0, 0, 0, 0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		// one bit over the longest code
		row = {make_request(CMD_ENTRY, 0, 8'h34, 8'(MAX_LEN + 1), 0, 0), 1'b1, 1'b1,
			error_outcome(ERR_LENGTH)};
		plan.push_back(row);
		row = {make_request(CMD_START, 0, 0, 0, 0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		// table {0, 10, 11}
		row = {make_request(CMD_ENTRY, 0, 8'hA5, 1, 64'h0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_ENTRY, 0, 8'h5A, 2, 64'h2, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_ENTRY, 0, 8'hFF, 2, 64'h3, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'h00), 1'b0, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'hFF), 1'b0, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'h9B), 1'b0, 1'b0, none};
		plan.push_back(row);
		// overwrite an existing leaf
		row = {make_request(CMD_ENTRY, 0, 8'h00, 1, 64'h0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'h40), 1'b0, 1'b0, none};
		plan.push_back(row);
		// code through a leaf turns it inner; 00 is then a missing branch
		row = {make_request(CMD_ENTRY, 0, 8'h11, 2, 64'h1, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'h00), 1'b1, 1'b1, error_outcome(ERR_BRANCH)};
		plan.push_back(row);
		// block of two symbols, longest code of all ones
		row = {make_request(CMD_START, 2, 0, 0, 0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_ENTRY, 0, 8'h00, 8'(MAX_LEN), '1, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_ENTRY, 0, 8'h80, 1, 64'h0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'h00), 1'b0, 1'b0, none};
		plan.push_back(row);
		// count reached: ignored
		row = {make_request(CMD_DATA, 0, 0, 0, 0, 8'h00), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_START, '1, 0, 0, 0, 0), 1'b1, 1'b0, none};
		plan.push_back(row);
		row = {make_request(CMD_ENTRY, 0, 8'h77, 8'hFF, {$urandom, $urandom}, 0), 1'b1, 1'b1,
			error_outcome(ERR_LENGTH)};
		plan.push_back(row);

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			offer(plan[i].req, !plan[i].known);
			if (plan[i].known && plan[i].known_n)
				results_due.push_back(plan[i].known_res);
		end
		drain_results();

		// Random blocks
		phase_no = 0;
		while (items_done < ITEM_GOAL) begin
			if (items_done >= ITEM_GOAL - 60)
				idle_on = 1'b0;
			pick = (phase_no == 0) ? 0 : $urandom_range(0, 9);
			if (pick == 0) begin
				// long random codes until the node store overflows
				r = random_request();
				r.cmd = CMD_START;
				r.block_symbols = '0;
				offer(r, 1'b1);
				repeat (12) begin
					r = random_request();
					r.cmd = CMD_ENTRY;
					r.code_length = 8'(MAX_LEN);
					offer(r, 1'b1);
				end
				repeat (2) begin
					r = random_request();
					r.cmd = CMD_DATA;
					offer(r, 1'b1);
				end
			end else if (pick <= 2) begin
				// noise: any command, lengths often out of range
				repeat ($urandom_range(4, 12)) begin
					r = random_request();
					if (r.cmd == CMD_ENTRY && $urandom_range(0, 1) == 0)
						r.code_length = 8'($urandom_range(1, 12));
					offer(r, 1'b1);
				end
			end else begin
				// well-formed block: start, prefix code table, data
				hold_now = !hold_done && items_done >= 120;
				r = random_request();
				r.cmd = CMD_START;
				pick = $urandom_range(0, 9);
				if (hold_now || pick < 4)
					r.block_symbols = '0;
				else if (pick < 8)
					r.block_symbols = $urandom_range(1, 30);
				offer(r, 1'b1);

				// complete prefix code by random splitting
				code_lens.delete();
				code_vals.delete();
				code_lens.push_back(8'd1);
				code_vals.push_back(64'd0);
				// the long hold needs a full table so every byte yields symbols
				leaves = hold_now ? $urandom_range(2, 12) : $urandom_range(1, 12);
				max_len = $urandom_range(1, 10);
				if (leaves > 1) begin
					code_lens.push_back(8'd1);
					code_vals.push_back(64'd1);
				end
				repeat (40) begin
					if (code_lens.size() < leaves) begin
						idx = $urandom_range(0, code_lens.size() - 1);
						if (code_lens[idx] < max_len) begin
							code_lens[idx] = code_lens[idx] + 8'd1;
							code_vals[idx] = code_vals[idx] << 1;
							code_lens.push_back(code_lens[idx]);
							code_vals.push_back(code_vals[idx] | 64'd1);
						end
					end
				end
				// sometimes leave a hole in the table
				if (!hold_now && code_lens.size() > 1 && $urandom_range(0, 3) == 0) begin
					idx = $urandom_range(0, code_lens.size() - 1);
					code_lens.delete(idx);
					code_vals.delete(idx);
				end
				foreach (code_lens[i]) begin
					r = random_request();
					r.cmd = CMD_ENTRY;
					r.code_length = code_lens[i];
					cv = {$urandom, $urandom};
					r.code_value = (code_lens[i] < CODE_W) ?
						((cv << code_lens[i]) | code_vals[i]) : code_vals[i];
					offer(r, 1'b1);
				end
				// rewrite one symbol in place
				if ($urandom_range(0, 5) == 0) begin
					r.entry_symbol = 8'($urandom_range(0, 255));
					offer(r, 1'b1);
				end

				n_bytes = hold_now ? 12 : $urandom_range(3, 12);
				if (hold_now) begin
					hold_ask = 1'b1;
					hold_done = 1'b1;
				end
				repeat (n_bytes) begin
					r = random_request();
					r.cmd = CMD_DATA;
					offer(r, 1'b1);
				end
			end
			if (phase_no % 4 == 3)
				drain_results();
			phase_no++;
		end

		drain_results();
		repeat (200) @(posedge clk);
		if (fail_count == 0)
			$display("[huffman_tree_decoder] OK");
		else
			$display("[huffman_tree_decoder] ERROR");
		$finish;
	end

endmodule
